@@ hw/rtl/ssfr_pkg.sv @@
// shared types, codes and pattern matchers of the serial screen frame receiver
`default_nettype none

package ssfr_pkg;

  // transaction modes
  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TAKE  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  localparam logic [7:0] START_BYTE = 8'hEE;
  localparam logic [7:0] CMD_FIRST  = 8'hA5;
  localparam logic [7:0] TAIL_FIRST = 8'hFF;
  localparam logic [2:0] CMD_LEN    = 3'd6;
  localparam logic [2:0] TAIL_LEN   = 3'd4;
  localparam int unsigned LEN_BITS  = 9;

  // store access request from the control path
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] wr_data;
  } store_req_t;

  // registered result fields, less the stored byte
  typedef struct packed {
    logic                frame_ready;
    logic [LEN_BITS-1:0] stored_len;
    logic                frame_taken;
    logic                query_taken;
    logic                rd_sel;
  } res_t;

  // command pattern A5 5A 03 00 07 01
  function automatic logic [7:0] cmd_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'hA5;
      3'd1:    b = 8'h5A;
      3'd2:    b = 8'h03;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h07;
      3'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // tail pattern FF FC FF FF
  function automatic logic [7:0] tail_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'hFF;
      3'd1:    b = 8'hFC;
      3'd2:    b = 8'hFF;
      3'd3:    b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // naive matcher step: advance, else restart on first pattern byte
  function automatic logic [2:0] cmd_next(input logic [2:0] pos, input logic [7:0] b);
    logic [2:0] n;
    if (pos < CMD_LEN && b == cmd_byte(pos)) n = pos + 3'd1;
    else if (b == CMD_FIRST)                 n = 3'd1;
    else                                     n = 3'd0;
    return n;
  endfunction

  function automatic logic [2:0] tail_next(input logic [2:0] pos, input logic [7:0] b);
    logic [2:0] n;
    if (pos < TAIL_LEN && b == tail_byte(pos)) n = pos + 3'd1;
    else if (b == TAIL_FIRST)                  n = 3'd1;
    else                                       n = 3'd0;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ssfr_item_if.sv @@
// input channel interface: one item per transaction
`default_nettype none

interface ssfr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;
  logic [8:0] read_index;
  logic [15:0] take_limit;

  modport source (output valid, mode, rx_byte, read_index, take_limit, input ready);
  modport sink   (input valid, mode, rx_byte, read_index, take_limit, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ssfr_result_if.sv @@
// result channel interface: one result per transaction
`default_nettype none

interface ssfr_result_if;
  logic       valid;
  logic       ready;
  logic       frame_ready;
  logic [8:0] stored_len;
  logic [7:0] read_byte;
  logic       frame_taken;
  logic       query_taken;

  modport source (output valid, frame_ready, stored_len, read_byte, frame_taken,
                  query_taken, input ready);
  modport sink   (input valid, frame_ready, stored_len, read_byte, frame_taken,
                  query_taken, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/serial_screen_frame_receiver.sv @@
// top level of the serial screen frame receiver
//
//   channel     dir  handshake      payload
//   item_in     in   valid/ready    mode, rx_byte, read_index, take_limit
//   result_out  out  valid/ready    frame_ready, stored_len, read_byte,
//                                   frame_taken, query_taken
//
// one item per cycle while no held result stalls the input; its result appears in the cycle after acceptance
// the frame memory is written and read at the acceptance edge; the read
// data register doubles as the output stage for stored bytes
// rst is synchronous; no memory clearing pass, stored bytes are undefined
// until written
// a held result blocks a new item only while result_out.ready is low
`default_nettype none

module serial_screen_frame_receiver #(
  parameter int unsigned FRAME_BYTES = 320
) (
  input wire logic       clk,
  input wire logic       rst,
  ssfr_item_if.sink      item_in,
  ssfr_result_if.source  result_out
);
  import ssfr_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);

  store_req_t    req;
  res_t          res;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data;

  ssfr_ctrl #(
    .FRAME_BYTES (FRAME_BYTES),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item_in.valid),
    .in_ready   (item_in.ready),
    .mode       (item_in.mode),
    .rx_byte    (item_in.rx_byte),
    .read_index (item_in.read_index),
    .take_limit (item_in.take_limit),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .res        (res),
    .req        (req),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr)
  );

  ssfr_store #(
    .FRAME_BYTES (FRAME_BYTES),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result payload
  assign result_out.frame_ready  = res.frame_ready;
  assign result_out.stored_len   = res.stored_len;
  assign result_out.read_byte    = res.rd_sel ? rd_data : 8'h00;
  assign result_out.frame_taken  = res.frame_taken;
  assign result_out.query_taken  = res.query_taken;

endmodule

`default_nettype wire

@@ hw/rtl/ssfr_store.sv @@
// frame byte memory, one write and one registered read per cycle
`default_nettype none

module ssfr_store #(
  parameter int unsigned FRAME_BYTES = 320,
  parameter int unsigned AW          = $clog2(FRAME_BYTES)
) (
  input  wire logic                   clk,
  input  wire ssfr_pkg::store_req_t   req,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [AW-1:0]          rd_addr,
  output      logic [7:0]             rd_data
);
  import ssfr_pkg::*;

  logic [7:0] mem [FRAME_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ssfr_ctrl.sv @@
// matchers, frame bookkeeping and result register
`default_nettype none

module ssfr_ctrl #(
  parameter int unsigned FRAME_BYTES = 320,
  parameter int unsigned AW          = $clog2(FRAME_BYTES),
  parameter int unsigned CW          = $clog2(FRAME_BYTES + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [1:0]           mode,
  input  wire logic [7:0]           rx_byte,
  input  wire logic [8:0]           read_index,
  input  wire logic [15:0]          take_limit,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      ssfr_pkg::res_t       res,
  output      ssfr_pkg::store_req_t req,
  output      logic [AW-1:0]        wr_addr,
  output      logic [AW-1:0]        rd_addr
);
  import ssfr_pkg::*;

  // index width holds both the read index and the store depth itself
  localparam int unsigned IW = (AW + 1 > 9) ? AW + 1 : 9;
  localparam int unsigned LW = (CW > LEN_BITS) ? CW : LEN_BITS;

  logic          accept;
  logic [CW-1:0] byte_count, byte_count_next;
  logic          ready_flag, ready_flag_next;
  logic [2:0]    tail_pos, tail_pos_next;
  logic [2:0]    cmd_pos, cmd_pos_next;
  logic          query_pending, query_pending_next;
  logic [IW-1:0] idx_ext;
  logic [LW-1:0] len_ext;
  logic          frame_taken, query_taken, rd_hit, wr_hit;
  res_t          res_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign idx_ext  = IW'(read_index);
  assign rd_addr  = idx_ext[AW-1:0];
  assign wr_addr  = byte_count[AW-1:0];

  // next state per mode
  always_comb begin
    byte_count_next    = byte_count;
    ready_flag_next    = ready_flag;
    tail_pos_next      = tail_pos;
    cmd_pos_next       = cmd_pos;
    query_pending_next = query_pending;
    frame_taken        = 1'b0;
    query_taken        = 1'b0;
    rd_hit             = 1'b0;
    wr_hit             = 1'b0;
    case (mode_t'(mode))
      MODE_RX: begin
        cmd_pos_next = cmd_next(cmd_pos, rx_byte);
        if (cmd_pos_next == CMD_LEN) begin
          query_pending_next = 1'b1;
          cmd_pos_next       = 3'd0;
        end
        if (!ready_flag && !(byte_count == '0 && rx_byte != START_BYTE)) begin
          if (byte_count < CW'(FRAME_BYTES)) begin
            wr_hit          = 1'b1;
            byte_count_next = byte_count + CW'(1);
            tail_pos_next   = tail_next(tail_pos, rx_byte);
            if (tail_pos_next == TAIL_LEN) begin
              ready_flag_next = 1'b1;
            end
          end else begin
            // overflow drops the frame
            byte_count_next = '0;
            tail_pos_next   = 3'd0;
          end
        end
      end
      MODE_READ: begin
        rd_hit = (idx_ext < IW'(FRAME_BYTES));
      end
      MODE_TAKE: begin
        if (ready_flag && byte_count != '0 && 16'(byte_count) <= take_limit) begin
          frame_taken     = 1'b1;
          byte_count_next = '0;
          tail_pos_next   = 3'd0;
          ready_flag_next = 1'b0;
        end
      end
      MODE_QUERY: begin
        if (query_pending) begin
          query_taken        = 1'b1;
          query_pending_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields; a take reports the length before the release
  always_comb begin
    len_ext               = (mode_t'(mode) == MODE_TAKE) ? LW'(byte_count)
                                                          : LW'(byte_count_next);
    res_next.frame_ready  = ready_flag_next;
    res_next.stored_len   = len_ext[LEN_BITS-1:0];
    res_next.frame_taken  = frame_taken;
    res_next.query_taken  = query_taken;
    res_next.rd_sel       = rd_hit;
  end

  assign req.wr_en   = accept && wr_hit;
  assign req.rd_en   = accept && rd_hit;
  assign req.wr_data = rx_byte;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      ready_flag    <= 1'b0;
      tail_pos      <= 3'd0;
      cmd_pos       <= 3'd0;
      query_pending <= 1'b0;
    end else if (accept) begin
      byte_count    <= byte_count_next;
      ready_flag    <= ready_flag_next;
      tail_pos      <= tail_pos_next;
      cmd_pos       <= cmd_pos_next;
      query_pending <= query_pending_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ssfr_checker.sv @@
// port-level checks of the frame receiver and their binding
`default_nettype none

module ssfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       frame_ready,
  input wire logic [8:0] stored_len,
  input wire logic       frame_taken,
  input wire logic       query_taken
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every accepted transaction yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction gave no result");

  // a taken frame is released and was not empty
  a_take_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_taken |-> !frame_ready && stored_len != 9'd0)
    else $error("taken frame still ready or empty");

  // a result comes from one mode only
  a_one_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_taken && query_taken))
    else $error("frame and query taken together");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind serial_screen_frame_receiver ssfr_checker u_ssfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item_in.valid),
  .in_ready     (item_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .frame_ready  (result_out.frame_ready),
  .stored_len   (result_out.stored_len),
  .frame_taken  (result_out.frame_taken),
  .query_taken  (result_out.query_taken)
);

`default_nettype wire
